@@ hdl/ipv4_rx_header_check_unit_assert.svh @@
// Assertion macros shared by the checker of the IPv4 receive header check unit.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef IPV4_RX_HEADER_CHECK_UNIT_ASSERT_SVH
`define IPV4_RX_HEADER_CHECK_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IPV4RX_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IPV4RX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/ipv4rx_pkg.sv @@
`default_nettype none

package ipv4rx_pkg;

    localparam int unsigned NUM_IFACE = 4;
    localparam int unsigned IFACE_W   = 2;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IFACE0_ADDR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IFACE3_ADDR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMISC     = 3'd4;

    localparam logic [3:0]  IP_VERSION_FOUR = 4'h4;
    localparam logic [3:0]  MIN_HDR_WORDS   = 4'd5;
    localparam logic [3:0]  PROTO_WORD      = 4'd3;
    localparam logic [3:0]  DST_ADDR_WORD   = 4'd5;
    localparam logic [15:0] MIN_TOTAL_LEN   = 16'd20;
    localparam logic [15:0] CSUM_GOOD       = 16'hFFFF;
    localparam logic [7:0]  PROTO_TCP       = 8'd6;
    localparam logic [7:0]  PROTO_ICMP      = 8'd1;

    typedef enum logic [2:0] {
        VERDICT_SHORT       = 3'd0,
        VERDICT_BAD_CSUM    = 3'd1,
        VERDICT_NOT_OURS    = 3'd2,
        VERDICT_BAD_VERSION = 3'd3,
        VERDICT_TCP         = 3'd4,
        VERDICT_ICMP        = 3'd5,
        VERDICT_OTHER       = 3'd6
    } t_verdict;

    typedef struct packed {
        logic [IFACE_W-1:0] iface;
        logic               first_word;
        logic [WORD_W-1:0]  header_word;
    } t_in_beat;

    typedef struct packed {
        t_verdict    verdict;
        logic [15:0] total_length;
        logic [3:0]  header_words;
        logic [7:0]  protocol_number;
    } t_result;

    typedef struct packed {
        logic [NUM_IFACE-1:0][WORD_W-1:0] iface_addr;
        logic                             promiscuous;
    } t_cfg;

    // Ones-complement 16-bit add with end-around carry.
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

`default_nettype wire

@@ hdl/ipv4rx_in_if.sv @@
`default_nettype none

interface ipv4rx_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  iface;
    logic        first_word;
    logic [31:0] header_word;

    modport source (output valid, output iface, output first_word, output header_word,
                    input ready);
    modport sink   (input valid, input iface, input first_word, input header_word,
                    output ready);
endinterface

`default_nettype wire

@@ hdl/ipv4rx_out_if.sv @@
`default_nettype none

interface ipv4rx_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [15:0] total_length;
    logic [3:0]  header_words;
    logic [7:0]  protocol_number;

    modport source (output valid, output verdict, output total_length,
                    output header_words, output protocol_number, input ready);
    modport sink   (input valid, input verdict, input total_length,
                    input header_words, input protocol_number, output ready);
endinterface

`default_nettype wire

@@ hdl/ipv4rx_in_reg.sv @@
`default_nettype none

module ipv4rx_in_reg (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire ipv4rx_pkg::t_in_beat i_beat,
    input  wire logic                i_adv,
    output logic                     o_ready,
    output logic                     o_valid,
    output ipv4rx_pkg::t_in_beat     o_beat
);
    import ipv4rx_pkg::*;

    logic     r_valid;
    t_in_beat r_beat;

    // The register takes a new beat when it is empty or its beat moves on now.
    assign o_ready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

`default_nettype wire

@@ hdl/ipv4rx_hdr_eval.sv @@
`default_nettype none

module ipv4rx_hdr_eval (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_step,
    input  wire ipv4rx_pkg::t_in_beat i_beat,
    input  wire ipv4rx_pkg::t_cfg     i_cfg,
    output logic                      o_res_valid,
    output ipv4rx_pkg::t_result       o_res
);
    import ipv4rx_pkg::*;

    logic        r_active;
    logic [3:0]  r_count;
    logic [15:0] r_sum;
    logic [3:0]  r_ihl;
    logic [15:0] r_tot;
    logic [3:0]  r_ver;
    logic [7:0]  r_proto;
    logic [1:0]  r_iface;
    logic        r_addr_ok;

    logic        first;
    logic        act;
    logic [31:0] w;
    logic [3:0]  base_count;
    logic [15:0] base_sum;
    logic [7:0]  base_proto;
    logic        base_addr_ok;
    logic [3:0]  cur_ihl;
    logic [3:0]  cur_ver;
    logic [15:0] cur_tot;
    logic [1:0]  cur_iface;
    logic [3:0]  n_count;
    logic [15:0] n_sum;
    logic [7:0]  n_proto;
    logic        n_addr_ok;
    logic        done;
    t_verdict    verdict;

    always_comb begin
        first = i_beat.first_word;
        w     = i_beat.header_word;
        act   = first || r_active;

        // A first word restarts all per-packet state.
        base_count   = first ? 4'd0  : r_count;
        base_sum     = first ? 16'd0 : r_sum;
        base_proto   = first ? 8'd0  : r_proto;
        base_addr_ok = first ? 1'b0  : r_addr_ok;
        cur_ihl      = first ? w[27:24] : r_ihl;
        cur_ver      = first ? w[31:28] : r_ver;
        cur_tot      = first ? w[15:0]  : r_tot;
        cur_iface    = first ? i_beat.iface : r_iface;

        n_count   = base_count + 4'd1;
        n_sum     = (n_count <= cur_ihl) ? oc_add(oc_add(base_sum, w[31:16]), w[15:0])
                                         : base_sum;
        n_proto   = (n_count == PROTO_WORD) ? w[23:16] : base_proto;
        n_addr_ok = (n_count == DST_ADDR_WORD) ? (w == i_cfg.iface_addr[cur_iface])
                                               : base_addr_ok;

        // Headers shorter than the minimum still wait for five words.
        done = (cur_ihl < MIN_HDR_WORDS) ? (n_count >= MIN_HDR_WORDS)
                                         : (n_count >= cur_ihl);

        if (cur_tot < MIN_TOTAL_LEN) begin
            verdict = VERDICT_SHORT;
        end else if (cur_ihl < MIN_HDR_WORDS || n_sum != CSUM_GOOD) begin
            verdict = VERDICT_BAD_CSUM;
        end else if (!i_cfg.promiscuous && !n_addr_ok) begin
            verdict = VERDICT_NOT_OURS;
        end else if (cur_ver != IP_VERSION_FOUR) begin
            verdict = VERDICT_BAD_VERSION;
        end else if (n_proto == PROTO_TCP) begin
            verdict = VERDICT_TCP;
        end else if (n_proto == PROTO_ICMP) begin
            verdict = VERDICT_ICMP;
        end else begin
            verdict = VERDICT_OTHER;
        end
    end

    assign o_res_valid           = i_step && act && done;
    assign o_res.verdict         = verdict;
    assign o_res.total_length    = cur_tot;
    assign o_res.header_words    = cur_ihl;
    assign o_res.protocol_number = n_proto;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_count  <= 4'd0;
        end else if (i_step && act) begin
            r_active <= !done;
            r_count  <= done ? 4'd0 : n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && act) begin
            r_sum     <= n_sum;
            r_ihl     <= cur_ihl;
            r_tot     <= cur_tot;
            r_ver     <= cur_ver;
            r_proto   <= n_proto;
            r_iface   <= cur_iface;
            r_addr_ok <= n_addr_ok;
        end
    end

endmodule

`default_nettype wire

@@ hdl/ipv4rx_out_reg.sv @@
`default_nettype none

module ipv4rx_out_reg (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire ipv4rx_pkg::t_result i_res,
    input  wire logic                i_ready,
    output logic                     o_adv,
    output logic                     o_valid,
    output ipv4rx_pkg::t_result      o_res
);
    import ipv4rx_pkg::*;

    logic    r_valid;
    t_result r_res;

    // The register can load whenever it is empty or its result is taken now.
    assign o_adv = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

@@ hdl/ipv4_rx_header_check_unit.sv @@
`default_nettype none

// IPv4 receive header check: takes a received header one big-endian 32-bit word per beat
// on i_in (first_word marks the start of a packet, iface is taken from that first beat)
// and gives one verdict beat on o_out per packet after max(ihl,5) words, with the total
// length, ihl and protocol fields. Verdicts, in priority order: short, bad checksum, not
// ours (skipped when promiscuous), bad version, then tcp, icmp or other. Words without a
// packet in progress are dropped, and a new first word abandons an unfinished packet
// without a verdict. The unit takes one beat every clock unless o_out stalls: each word
// passes through an input register, the field latching, checksum add and verdict logic,
// and a result register, so o_out.valid is set once the last word of a packet has moved
// from the input register into the result register. i_in.ready only drops while a
// verdict waits in the result register and another word is already waiting behind it.
// Configuration registers (interface addresses 0 to 3, promiscuous) are written through
// i_cfg_we/i_cfg_index/i_cfg_data and must only change while no packet is in flight.
module ipv4_rx_header_check_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ipv4rx_in_if.sink        i_in,
    ipv4rx_out_if.source     o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [ipv4rx_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ipv4rx_pkg::WORD_W-1:0]    i_cfg_data
);
    import ipv4rx_pkg::*;

    // Configuration registers.
    logic [NUM_IFACE-1:0][WORD_W-1:0] r_iface_addr;
    logic                             r_promisc;
    t_cfg                             cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iface_addr <= '0;
            r_promisc    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index) inside
                [CFG_IFACE0_ADDR:CFG_IFACE3_ADDR]: begin
                    r_iface_addr[i_cfg_index[IFACE_W-1:0]] <= i_cfg_data;
                end
                CFG_PROMISC: begin
                    r_promisc <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg.iface_addr  = r_iface_addr;
    assign cfg.promiscuous = r_promisc;

    // Input beat capture.
    t_in_beat in_beat;
    t_in_beat stg_beat;
    logic     stg_valid;
    logic     adv;
    logic     in_ready;

    assign in_beat.iface       = i_in.iface;
    assign in_beat.first_word  = i_in.first_word;
    assign in_beat.header_word = i_in.header_word;

    ipv4rx_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_beat  (in_beat),
        .i_adv   (adv),
        .o_ready (in_ready),
        .o_valid (stg_valid),
        .o_beat  (stg_beat)
    );

    assign i_in.ready = in_ready;

    // Per-packet state and verdict; a registered word is processed whenever the
    // result register can take whatever it produces.
    logic    res_valid;
    t_result res;

    ipv4rx_hdr_eval u_hdr_eval (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (stg_valid && adv),
        .i_beat      (stg_beat),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register toward the downstream side.
    logic    out_valid;
    t_result out_res;

    ipv4rx_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_res   (res),
        .i_ready (o_out.ready),
        .o_adv   (adv),
        .o_valid (out_valid),
        .o_res   (out_res)
    );

    assign o_out.valid           = out_valid;
    assign o_out.verdict         = out_res.verdict;
    assign o_out.total_length    = out_res.total_length;
    assign o_out.header_words    = out_res.header_words;
    assign o_out.protocol_number = out_res.protocol_number;

endmodule

`default_nettype wire

@@ hdl/ipv4rx_checker.sv @@
`default_nettype none

`include "ipv4_rx_header_check_unit_assert.svh"

module ipv4rx_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  i_verdict,
    input wire logic [15:0] i_total_length,
    input wire logic [3:0]  i_header_words,
    input wire logic [7:0]  i_protocol_number
);
    import ipv4rx_pkg::*;

    logic        in_beat;
    logic        out_stall;
    logic [30:0] out_fields;
    logic        not_short;
    logic        len_ok;

    assign in_beat    = i_in_valid && i_in_ready;
    assign out_stall  = i_out_valid && !i_out_ready;
    assign out_fields = {i_verdict, i_total_length, i_header_words, i_protocol_number};
    assign not_short  = i_out_valid && (i_verdict != VERDICT_SHORT);
    assign len_ok     = i_total_length >= MIN_TOTAL_LEN;

    // A stalled verdict beat keeps its contents.
    `IPV4RX_ASSERT_NEXT(a_out_hold, out_stall, i_out_valid && $stable(out_fields), "beat changed")

    // The input side only backs up behind a stalled verdict.
    `IPV4RX_ASSERT_SAME(a_ready_stall, !i_in_ready, out_stall, "input stall without backpressure")

    // A fresh verdict follows an accepted input beat, registered in turn by the input and result registers.
    `IPV4RX_ASSERT_SAME(a_out_origin, $rose(i_out_valid), $past(in_beat, 2), "orphan verdict")

    // Any verdict other than short implies a total length of at least twenty.
    `IPV4RX_ASSERT_SAME(a_short_len, not_short, len_ok, "short packet not flagged")

endmodule

bind ipv4_rx_header_check_unit ipv4rx_checker u_ipv4rx_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_verdict         (o_out.verdict),
    .i_total_length    (o_out.total_length),
    .i_header_words    (o_out.header_words),
    .i_protocol_number (o_out.protocol_number)
);

`default_nettype wire

@@ verif/testbench.sv @@
`default_nettype none

// Self-checking bench for the IPv4 receive header check unit.
//
// Header words are queued as whole packets by the stimulus process. A clocked
// driver feeds them to the header channel, and a clocked monitor keeps its own
// copy of the checker state. For every accepted header beat, that copy works
// out whether a verdict is due and what it must be. Verdict beats on the
// output channel are compared field by field against the oldest waiting
// prediction.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ipv4rx_pkg::*;

    // A verdict leaves the unit after passing its input and result registers. The settle
    // time comfortably covers a word that is still in the pipe but causes no verdict.
    localparam int SETTLE_CYCLES = 8;
    // Cycles with no beat accepted on either channel before the run is called hung.
    localparam int QUIET_LIMIT   = 3000;
    // Length of the deliberate receiver hold-off that backs the unit up.
    localparam int LONG_STALL    = 400;
    localparam int PHASE_BEATS   = 100;
    localparam int MAX_REPORTS   = 10;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    ipv4rx_in_if  hdr_if ();
    ipv4rx_out_if verdict_if ();

    ipv4_rx_header_check_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (hdr_if),
        .o_out       (verdict_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Header words waiting to be offered, and verdicts the unit still owes us.
    t_in_beat hdr_beat_q[$];
    t_result  verdict_q[$];

    // Our copy of the configuration registers, updated as they are written.
    logic [WORD_W-1:0] local_addr [NUM_IFACE];
    logic              promisc_on;

    // Our copy of the per-packet checker state.
    logic        pkt_open;
    logic [3:0]  words_seen;
    logic [15:0] csum_run;
    logic [3:0]  pkt_ihl;
    logic [15:0] pkt_tot_len;
    logic [3:0]  pkt_version;
    logic [7:0]  pkt_proto;
    logic [1:0]  pkt_iface;
    logic        dst_hit;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    logic        long_stall_req;
    logic        long_stall_ack;
    int          long_stall_left;
    int          quiet_cycles;
    int          mismatch_count;
    t_in_beat    next_beat;

    always #2 clk = ~clk;

    // Ones-complement add of two 16-bit halves, with the carry folded back in.
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] total;
        total = 32'(a) + 32'(b);
        total = 32'(total[15:0]) + 32'(total[31:16]);
        return total[15:0];
    endfunction

    // Advance our copy of the checker by one accepted header word. Returns 1 and
    // fills the verdict when this word completes a packet.
    function automatic bit predict_verdict(input t_in_beat beat, output t_result res);
        logic [3:0] n;
        logic [3:0] need;
        t_verdict   v;
        res = '0;
        if (beat.first_word) begin
            // A first word always opens a fresh packet, abandoning any packet
            // that was still in progress without a verdict.
            pkt_open    = 1'b1;
            words_seen  = '0;
            csum_run    = '0;
            dst_hit     = 1'b0;
            pkt_proto   = '0;
            pkt_iface   = beat.iface;
            pkt_version = beat.header_word[31:28];
            pkt_ihl     = beat.header_word[27:24];
            pkt_tot_len = beat.header_word[15:0];
        end else if (!pkt_open) begin
            // Stray continuation words with no packet open are dropped.
            return 1'b0;
        end

        n = words_seen + 4'd1;
        words_seen = n;

        // Only the first ihl words take part in the checksum.
        if (n <= pkt_ihl) begin
            csum_run = ones_add(ones_add(csum_run, beat.header_word[31:16]),
                                beat.header_word[15:0]);
        end
        if (n == PROTO_WORD) begin
            pkt_proto = beat.header_word[23:16];
        end
        if (n == DST_ADDR_WORD) begin
            dst_hit = (beat.header_word == local_addr[pkt_iface]);
        end

        // Even with a short ihl the unit reads a full minimum header first.
        need = (pkt_ihl < MIN_HDR_WORDS) ? MIN_HDR_WORDS : pkt_ihl;
        if (n < need) begin
            return 1'b0;
        end

        if (pkt_tot_len < MIN_TOTAL_LEN) begin
            v = VERDICT_SHORT;
        end else if (pkt_ihl < MIN_HDR_WORDS || csum_run != CSUM_GOOD) begin
            v = VERDICT_BAD_CSUM;
        end else if (!promisc_on && !dst_hit) begin
            v = VERDICT_NOT_OURS;
        end else if (pkt_version != IP_VERSION_FOUR) begin
            v = VERDICT_BAD_VERSION;
        end else if (pkt_proto == PROTO_TCP) begin
            v = VERDICT_TCP;
        end else if (pkt_proto == PROTO_ICMP) begin
            v = VERDICT_ICMP;
        end else begin
            v = VERDICT_OTHER;
        end

        res.verdict         = v;
        res.total_length    = pkt_tot_len;
        res.header_words    = pkt_ihl;
        res.protocol_number = pkt_proto;
        pkt_open   = 1'b0;
        words_seen = '0;
        return 1'b1;
    endfunction

    // Build one header and queue its words. The checksum field is computed so
    // that the header sums correctly, then optionally corrupted. A nonzero
    // cut_at below the header size queues only that many words, so the next
    // first word restarts the unit mid-packet. Returns the words queued.
    function automatic int queue_header(input logic [1:0] ifc, input logic [3:0] ihl,
                                        input logic [15:0] tot_len, input logic [3:0] version,
                                        input logic [7:0] proto, input bit dst_ours,
                                        input bit csum_ok, input int cut_at);
        logic [31:0] words [1:15];
        logic [15:0] sum;
        int          need;
        int          sent;
        int          flip;
        t_in_beat    beat;
        need = (ihl < MIN_HDR_WORDS) ? int'(MIN_HDR_WORDS) : int'(ihl);
        sent = (cut_at > 0 && cut_at < need) ? cut_at : need;
        for (int i = 1; i <= 15; i++) begin
            words[i] = $urandom();
        end
        words[1]        = {version, ihl, words[1][23:16], tot_len};
        words[3][23:16] = proto;
        words[3][15:0]  = 16'h0000;
        // A foreign destination always differs from the local address in bit 0.
        words[5] = dst_ours ? local_addr[ifc] : (local_addr[ifc] ^ ($urandom() | 32'h1));
        sum = '0;
        for (int i = 1; i <= int'(ihl); i++) begin
            sum = ones_add(ones_add(sum, words[i][31:16]), words[i][15:0]);
        end
        words[3][15:0] = ~sum;
        if (!csum_ok) begin
            flip = $urandom_range(15, 0);
            words[3][flip] = ~words[3][flip];
        end
        for (int i = 1; i <= sent; i++) begin
            beat.iface       = ifc;
            beat.first_word  = (i == 1);
            beat.header_word = words[i];
            hdr_beat_q.push_back(beat);
        end
        return sent;
    endfunction

    // Mostly well-formed packets with random content, plus stray words and
    // packets cut short by a restart. Stray words are not counted.
    task automatic queue_random_traffic(input int n_beats);
        int          counted;
        int          pick;
        int          need;
        int          cut;
        logic [3:0]  ihl;
        logic [15:0] tot_len;
        logic [3:0]  version;
        logic [7:0]  proto;
        t_in_beat    beat;
        counted = 0;
        while (counted < n_beats) begin
            if ($urandom_range(99) < 5) begin
                beat.iface       = 2'($urandom());
                beat.first_word  = 1'b0;
                beat.header_word = $urandom();
                hdr_beat_q.push_back(beat);
            end else begin
                // Most headers are minimum size; a few carry options or a bogus ihl.
                pick = $urandom_range(99);
                if (pick < 55) begin
                    ihl = MIN_HDR_WORDS;
                end else if (pick < 85) begin
                    ihl = 4'($urandom_range(15, 6));
                end else begin
                    ihl = 4'($urandom_range(4, 0));
                end
                need = (ihl < MIN_HDR_WORDS) ? int'(MIN_HDR_WORDS) : int'(ihl);
                cut  = ($urandom_range(99) < 8) ? $urandom_range(need - 1, 1) : 0;
                tot_len = ($urandom_range(99) < 10) ? 16'($urandom_range(19, 0))
                                                    : 16'($urandom_range(65535, 20));
                version = ($urandom_range(99) < 88) ? IP_VERSION_FOUR : 4'($urandom());
                pick = $urandom_range(99);
                if (pick < 35) begin
                    proto = PROTO_TCP;
                end else if (pick < 65) begin
                    proto = PROTO_ICMP;
                end else begin
                    proto = 8'($urandom());
                end
                counted += queue_header(2'($urandom()), ihl, tot_len, version, proto,
                                        $urandom_range(99) < 80, $urandom_range(99) < 85,
                                        cut);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx <= CFG_IFACE3_ADDR) begin
            local_addr[idx[1:0]] = data;
        end else if (idx == CFG_PROMISC) begin
            promisc_on = data[0];
        end
    endtask

    task automatic set_config(input logic [WORD_W-1:0] a0, input logic [WORD_W-1:0] a1,
                              input logic [WORD_W-1:0] a2, input logic [WORD_W-1:0] a3,
                              input logic promisc);
        logic [WORD_W-1:0] addrs [NUM_IFACE];
        addrs = '{a0, a1, a2, a3};
        for (int k = 0; k < NUM_IFACE; k++) begin
            write_reg(CFG_IFACE0_ADDR + CFG_IDX_W'(k), addrs[k]);
        end
        write_reg(CFG_PROMISC, {{(WORD_W-1){1'b0}}, promisc});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct  <= send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // Wait until every queued word has been taken and every predicted verdict has
    // arrived, then give a word that causes no verdict time to clear the pipe.
    task automatic wait_drained();
        while (hdr_beat_q.size() != 0 || hdr_if.valid || verdict_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic flag_mismatch(input string what, input t_result want, input t_result got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s", $time, what);
            $display("    expected verdict=%0d total_length=%0d ihl=%0d protocol=%0d",
                     want.verdict, want.total_length, want.header_words,
                     want.protocol_number);
            $display("    actual   verdict=%0d total_length=%0d ihl=%0d protocol=%0d",
                     got.verdict, got.total_length, got.header_words, got.protocol_number);
        end
    endtask

    // Header driver. A new word is offered only when the channel is free or the
    // current beat is being taken at this edge, so a word under stall holds.
    always @(posedge clk) begin
        if (!rst_n) begin
            hdr_if.valid <= 1'b0;
        end else if (!hdr_if.valid || hdr_if.ready) begin
            if (hdr_beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_beat = hdr_beat_q.pop_front();
                hdr_if.valid       <= 1'b1;
                hdr_if.iface       <= next_beat.iface;
                hdr_if.first_word  <= next_beat.first_word;
                hdr_if.header_word <= next_beat.header_word;
            end else begin
                hdr_if.valid <= 1'b0;
            end
        end
    end

    // The long hold-off is counted here. Each toggle of the request starts one.
    always @(posedge clk) begin
        if (!rst_n) begin
            long_stall_left <= 0;
            long_stall_ack  <= 1'b0;
        end else if (long_stall_req != long_stall_ack) begin
            long_stall_left <= LONG_STALL;
            long_stall_ack  <= long_stall_req;
        end else if (long_stall_left != 0) begin
            long_stall_left <= long_stall_left - 1;
        end
    end

    // Verdict receiver: random stalls, plus the long hold-off when one runs.
    always @(posedge clk) begin
        if (!rst_n) begin
            verdict_if.ready <= 1'b0;
        end else begin
            verdict_if.ready <= (long_stall_left == 0) &&
                                ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor. Values read here are the ones that were stable before this edge.
    always @(posedge clk) begin
        t_result want;
        t_result got;
        if (rst_n) begin
            if (hdr_if.valid && hdr_if.ready) begin
                if (predict_verdict('{hdr_if.iface, hdr_if.first_word, hdr_if.header_word},
                                    want)) begin
                    verdict_q.push_back(want);
                end
            end
            if (verdict_if.valid && verdict_if.ready) begin
                got.verdict         = t_verdict'(verdict_if.verdict);
                got.total_length    = verdict_if.total_length;
                got.header_words    = verdict_if.header_words;
                got.protocol_number = verdict_if.protocol_number;
                if (verdict_q.size() == 0) begin
                    flag_mismatch("verdict beat with no packet completed", '0, got);
                end else begin
                    want = verdict_q.pop_front();
                    if (got.verdict != want.verdict ||
                        got.total_length != want.total_length ||
                        got.header_words != want.header_words ||
                        got.protocol_number != want.protocol_number) begin
                        flag_mismatch("verdict beat differs", want, got);
                    end
                end
            end
        end
    end

    // Watchdog: the run is hung if neither channel moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (hdr_if.valid && hdr_if.ready) ||
            (verdict_if.valid && verdict_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_IFACE0_ADDR;
        cfg_data           = '0;
        hdr_if.valid       = 1'b0;
        hdr_if.iface       = '0;
        hdr_if.first_word  = 1'b0;
        hdr_if.header_word = '0;
        verdict_if.ready   = 1'b0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        long_stall_req     = 1'b0;
        quiet_cycles       = 0;
        mismatch_count     = 0;
        promisc_on         = 1'b0;
        for (int k = 0; k < NUM_IFACE; k++) begin
            local_addr[k] = '0;
        end
        pkt_open    = 1'b0;
        words_seen  = '0;
        csum_run    = '0;
        pkt_ihl     = '0;
        pkt_tot_len = '0;
        pkt_version = '0;
        pkt_proto   = '0;
        pkt_iface   = '0;
        dst_hit     = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed packets, addresses at both extremes and promiscuous off.
        set_config(32'hC0A8_0001, 32'h0000_0000, 32'h0A00_0002, 32'hFFFF_FFFF, 1'b0);
        set_idling(0, 0);
        // A continuation word while idle must be ignored.
        hdr_beat_q.push_back('{2'd3, 1'b0, 32'hFFFF_FFFF});
        // Total length of zero wins over everything else.
        void'(queue_header(2'd0, MIN_HDR_WORDS, 16'd0, IP_VERSION_FOUR, PROTO_TCP,
                           1'b1, 1'b1, 0));
        // An ihl below the minimum reads as a bad checksum; length right at the limit.
        void'(queue_header(2'd1, 4'd4, MIN_TOTAL_LEN, IP_VERSION_FOUR, PROTO_ICMP,
                           1'b1, 1'b1, 0));
        // A packet abandoned after two words, then a clean one at maximum length
        // on the interface whose address is all ones.
        void'(queue_header(2'd2, MIN_HDR_WORDS, 16'd100, IP_VERSION_FOUR, PROTO_TCP,
                           1'b1, 1'b1, 2));
        void'(queue_header(2'd3, MIN_HDR_WORDS, 16'hFFFF, IP_VERSION_FOUR, PROTO_ICMP,
                           1'b1, 1'b1, 0));
        // Good header sent to somebody else.
        void'(queue_header(2'd2, MIN_HDR_WORDS, 16'd40, IP_VERSION_FOUR, PROTO_TCP,
                           1'b0, 1'b1, 0));
        wait_drained();

        // Random traffic with no idling on either side.
        set_config($urandom(), $urandom(), $urandom(), $urandom(), 1'b0);
        set_idling(0, 0);
        queue_random_traffic(PHASE_BEATS);
        wait_drained();

        // Promiscuous, with a sparse sender.
        set_config(32'h0000_0000, 32'hFFFF_FFFF, $urandom(), $urandom(), 1'b1);
        set_idling(84, 0);
        queue_random_traffic(PHASE_BEATS);
        wait_drained();

        // A slow receiver, opening with a long hold-off so the unit backs up and
        // drops ready while the driver keeps offering words.
        set_config($urandom(), $urandom(), $urandom(), $urandom(), 1'b0);
        set_idling(0, 84);
        long_stall_req <= ~long_stall_req;
        queue_random_traffic(PHASE_BEATS);
        wait_drained();

        // Light idling on both sides, promiscuous again.
        set_config(32'hFFFF_FFFF, 32'h0000_0000, $urandom(), $urandom(), 1'b1);
        set_idling(18, 18);
        queue_random_traffic(PHASE_BEATS);
        wait_drained();

        // Any prediction still waiting is a verdict the unit never gave.
        mismatch_count += verdict_q.size();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
